@@ rtl/sparse_scaled_merge_sum_assert.svh @@
// ----------------------------------------------------------------------------
// sparse_scaled_merge_sum_assert.svh
// Assertion macros used by the merge block.
// ----------------------------------------------------------------------------
`ifndef SPARSE_SCALED_MERGE_SUM_ASSERT_SVH
`define SPARSE_SCALED_MERGE_SUM_ASSERT_SVH

// same-cycle implication
`define SSM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssm: same-cycle check failed");

// next-cycle implication
`define SSM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssm: next-cycle check failed");

`endif

@@ rtl/ssm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, codes and helpers of the sparse scaled merge block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssm_pkg;

   localparam int DEFAULT_DEPTH       = 16;
   localparam int DEFAULT_INDEX_WIDTH = 16;
   localparam int Q_WIDTH             = 32;
   localparam int FIELD_INDEX_WIDTH   = 16;
   localparam int ACTION_WIDTH        = 2;
   localparam int CSR_INDEX_WIDTH     = 1;
   localparam int PROD_WIDTH          = 2 * Q_WIDTH;
   localparam int FRAC_BITS           = 16;

   localparam logic [Q_WIDTH-1:0] SCALE_RESET = 32'h0001_0000;

   localparam logic [ACTION_WIDTH-1:0] ACT_LOAD_LEFT  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_LOAD_RIGHT = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_RUN        = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEFT_SCALE  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RIGHT_SCALE = 1'd1;

   // which sides contribute to the current result
   typedef struct packed {
      logic use_left;
      logic use_right;
   } sel_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

@@ rtl/ssm_ram.sv @@
// ----------------------------------------------------------------------------
// ssm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = ssm_pkg::addr_width(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ssm_scale_add.sv @@
// ----------------------------------------------------------------------------
// ssm_scale_add
// Two-stage Q16.16 scale-and-add: registered products, then floor shift,
// saturation and saturated sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssm_scale_add (
   input  logic                           clock,
   input  logic                           load,
   input  ssm_pkg::sel_type               sel,
   input  logic signed [ssm_pkg::Q_WIDTH-1:0] left_scale,
   input  logic signed [ssm_pkg::Q_WIDTH-1:0] right_scale,
   input  logic signed [ssm_pkg::Q_WIDTH-1:0] left_value,
   input  logic signed [ssm_pkg::Q_WIDTH-1:0] right_value,
   output logic signed [ssm_pkg::Q_WIDTH-1:0] sum_value,
   output logic                           sum_sat
);
   import ssm_pkg::*;

   logic signed [PROD_WIDTH-1:0] prod_l_ff, prod_l_in;
   logic signed [PROD_WIDTH-1:0] prod_r_ff, prod_r_in;
   sel_type                      sel_ff;

   assign prod_l_in = left_scale * left_value;
   assign prod_r_in = right_scale * right_value;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
         sel_ff    <= sel;
      end
   end

   logic signed [PROD_WIDTH-1:0] shl, shr;
   logic signed [Q_WIDTH-1:0]    ql, qr;
   logic                         sat_l, sat_r, sat_s;
   logic signed [Q_WIDTH:0]      sum_w;

   always_comb begin
      shl   = prod_l_ff >>> FRAC_BITS;
      shr   = prod_r_ff >>> FRAC_BITS;
      sat_l = 1'b0;
      sat_r = 1'b0;
      // upper bits must all match the sign of the kept word
      if (!sel_ff.use_left) begin
         ql = '0;
      end else if (&shl[PROD_WIDTH-1:Q_WIDTH-1] || ~|shl[PROD_WIDTH-1:Q_WIDTH-1]) begin
         ql = shl[Q_WIDTH-1:0];
      end else begin
         sat_l = 1'b1;
         ql    = shl[PROD_WIDTH-1] ? {1'b1, {(Q_WIDTH-1){1'b0}}} : {1'b0, {(Q_WIDTH-1){1'b1}}};
      end
      if (!sel_ff.use_right) begin
         qr = '0;
      end else if (&shr[PROD_WIDTH-1:Q_WIDTH-1] || ~|shr[PROD_WIDTH-1:Q_WIDTH-1]) begin
         qr = shr[Q_WIDTH-1:0];
      end else begin
         sat_r = 1'b1;
         qr    = shr[PROD_WIDTH-1] ? {1'b1, {(Q_WIDTH-1){1'b0}}} : {1'b0, {(Q_WIDTH-1){1'b1}}};
      end
      sum_w = {ql[Q_WIDTH-1], ql} + {qr[Q_WIDTH-1], qr};
      sat_s = sum_w[Q_WIDTH] != sum_w[Q_WIDTH-1];
      if (sat_s) begin
         sum_value = sum_w[Q_WIDTH] ? {1'b1, {(Q_WIDTH-1){1'b0}}}
                                    : {1'b0, {(Q_WIDTH-1){1'b1}}};
      end else begin
         sum_value = sum_w[Q_WIDTH-1:0];
      end
      sum_sat = sat_l | sat_r | sat_s;
   end

endmodule

@@ rtl/sparse_scaled_merge_sum.sv @@
// A load word is stored at its accepting edge; loads go one per cycle while idle.
// A run word passes list fetch, multiply and saturate/add into the output register
// before its first result shows; later results come from the multiply/add loop on
// the list RAMs, and rsp_tready can stall them.
// An empty run's marker shows once the output register is free; req_tready is low for a run.
// Reset (synchronous): counts and drop flag cleared, scales set to 1.0; RAMs keep contents.
// ----------------------------------------------------------------------------
// sparse_scaled_merge_sum
// Stores two sorted sparse vectors and, on a run word, merges them into
// left_scale*a + right_scale*b in ascending index order, then clears them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sparse_scaled_merge_sum_assert.svh"

module sparse_scaled_merge_sum #(
   parameter int DEPTH       = ssm_pkg::DEFAULT_DEPTH,
   parameter int INDEX_WIDTH = ssm_pkg::DEFAULT_INDEX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] entry_index, [47:16] entry_value
   input  logic [ssm_pkg::ACTION_WIDTH-1:0] req_tuser,   // [1:0] action
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] out_index, [47:16] out_value
   output logic [2:0]  rsp_tuser,   // [0] empty_mark, [1] overflowed, [2] saturated
   output logic        rsp_tlast,   // last
   // configuration write port
   input  logic        csr_we,
   input  logic [ssm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ssm_pkg::Q_WIDTH-1:0]         csr_wdata
);
   import ssm_pkg::*;

   localparam int AW = addr_width(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int RW = INDEX_WIDTH + Q_WIDTH;   // RAM word: {value, index}

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,   // list heads being read
      S_MUL,     // heads valid: pick side, start multiply
      S_ADD,     // sum ready: push to output register
      S_MARK     // empty-run marker waiting for output register
   } state_type;

   // ---------------------------------------------------------------- state
   state_type               state_ff, state_in;
   logic [CW-1:0]           lcnt_ff, lcnt_in;
   logic [CW-1:0]           rcnt_ff, rcnt_in;
   logic                    drop_ff, drop_in;
   logic [CW-1:0]           i_ff, i_in;     // left read head
   logic [CW-1:0]           j_ff, j_in;     // right read head
   logic [INDEX_WIDTH-1:0]  hold_idx_ff, hold_idx_in;
   logic                    hold_last_ff, hold_last_in;
   logic [Q_WIDTH-1:0]      lscale_ff, lscale_in;
   logic [Q_WIDTH-1:0]      rscale_ff, rscale_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [FIELD_INDEX_WIDTH-1:0] rsp_index_ff, rsp_index_in;
   logic [Q_WIDTH-1:0]           rsp_value_ff, rsp_value_in;
   logic                         rsp_empty_ff, rsp_empty_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;
   logic                         rsp_sat_ff, rsp_sat_in;
   logic                         rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- RAMs
   logic                    lwr_en, rwr_en;
   logic [RW-1:0]           wr_word;
   logic [RW-1:0]           lrd, rrd;
   logic [INDEX_WIDTH-1:0]  load_idx;

   assign load_idx = INDEX_WIDTH'(32'(req_tdata[FIELD_INDEX_WIDTH-1:0]));
   assign wr_word  = {req_tdata[47:16], load_idx};

   ssm_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_left_ram (
      .clock   (clock),
      .wr_en   (lwr_en),
      .wr_addr (lcnt_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_addr (i_ff[AW-1:0]),
      .rd_data (lrd)
   );

   ssm_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_right_ram (
      .clock   (clock),
      .wr_en   (rwr_en),
      .wr_addr (rcnt_ff[AW-1:0]),
      .wr_data (wr_word),
      .rd_addr (j_ff[AW-1:0]),
      .rd_data (rrd)
   );

   logic [INDEX_WIDTH-1:0] l_idx, r_idx;
   assign l_idx = lrd[INDEX_WIDTH-1:0];
   assign r_idx = rrd[INDEX_WIDTH-1:0];

   // ---------------------------------------------------------------- merge pick
   logic    has_l, has_r, match, take_l;
   sel_type sel;

   always_comb begin
      has_l         = i_ff < lcnt_ff;
      has_r         = j_ff < rcnt_ff;
      match         = has_l && has_r && (l_idx == r_idx);
      take_l        = match || !has_r || (has_l && (l_idx < r_idx));
      sel.use_left  = take_l;
      sel.use_right = match || !take_l;
   end

   // ---------------------------------------------------------------- arithmetic
   logic               mul_load;
   logic [Q_WIDTH-1:0] sum_value;
   logic               sum_sat;

   assign mul_load = (state_ff == S_MUL);

   ssm_scale_add u_scale_add (
      .clock       (clock),
      .load        (mul_load),
      .sel         (sel),
      .left_scale  (lscale_ff),
      .right_scale (rscale_ff),
      .left_value  (lrd[RW-1:INDEX_WIDTH]),
      .right_value (rrd[RW-1:INDEX_WIDTH]),
      .sum_value   (sum_value),
      .sum_sat     (sum_sat)
   );

   // ---------------------------------------------------------------- control
   logic req_fire, rsp_free, rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = ((state_ff == S_ADD) || (state_ff == S_MARK)) && rsp_free;

   always_comb begin
      state_in     = state_ff;
      lcnt_in      = lcnt_ff;
      rcnt_in      = rcnt_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      hold_idx_in  = hold_idx_ff;
      hold_last_in = hold_last_ff;
      lscale_in    = lscale_ff;
      rscale_in    = rscale_ff;
      lwr_en       = 1'b0;
      rwr_en       = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_LEFT_SCALE:  lscale_in = csr_wdata;
            CSR_RIGHT_SCALE: rscale_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  ACT_LOAD_LEFT: begin
                     if (lcnt_ff == CW'(DEPTH)) begin
                        drop_in = 1'b1;
                     end else begin
                        lwr_en  = 1'b1;
                        lcnt_in = lcnt_ff + 1'b1;
                     end
                  end
                  ACT_LOAD_RIGHT: begin
                     if (rcnt_ff == CW'(DEPTH)) begin
                        drop_in = 1'b1;
                     end else begin
                        rwr_en  = 1'b1;
                        rcnt_in = rcnt_ff + 1'b1;
                     end
                  end
                  ACT_RUN: begin
                     i_in = '0;
                     j_in = '0;
                     if (lcnt_ff == '0 && rcnt_ff == '0) begin
                        state_in = S_MARK;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  default: ;   // unused action code: ignored
               endcase
            end
         end
         S_FETCH: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            // heads advance now; RAMs re-read them while the sum settles
            hold_idx_in  = take_l ? l_idx : r_idx;
            i_in         = i_ff + CW'(sel.use_left);
            j_in         = j_ff + CW'(sel.use_right);
            hold_last_in = (i_in >= lcnt_ff) && (j_in >= rcnt_ff);
            state_in     = S_ADD;
         end
         S_ADD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = FIELD_INDEX_WIDTH'(32'(hold_idx_ff));
               rsp_value_in = sum_value;
               rsp_empty_in = 1'b0;
               rsp_ovf_in   = drop_ff;
               rsp_sat_in   = sum_sat;
               rsp_last_in  = hold_last_ff;
               if (hold_last_ff) begin
                  lcnt_in  = '0;
                  rcnt_in  = '0;
                  drop_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MARK: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_value_in = '0;
               rsp_empty_in = 1'b1;
               rsp_ovf_in   = drop_ff;
               rsp_sat_in   = 1'b0;
               rsp_last_in  = 1'b1;
               drop_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lcnt_ff      <= '0;
         rcnt_ff      <= '0;
         drop_ff      <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         hold_last_ff <= 1'b0;
         lscale_ff    <= SCALE_RESET;
         rscale_ff    <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcnt_ff      <= lcnt_in;
         rcnt_ff      <= rcnt_in;
         drop_ff      <= drop_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         hold_last_ff <= hold_last_in;
         lscale_ff    <= lscale_in;
         rscale_ff    <= rscale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_idx_ff  <= hold_idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_index_ff};
   assign rsp_tuser  = {rsp_sat_ff, rsp_ovf_ff, rsp_empty_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   logic cnt_ok, last_load, lists_clear, marker_ok;

   assign cnt_ok      = (lcnt_ff <= CW'(DEPTH)) && (rcnt_ff <= CW'(DEPTH));
   assign last_load   = rsp_load && (state_ff == S_ADD) && hold_last_ff;
   assign lists_clear = (lcnt_ff == '0) && (rcnt_ff == '0) && !drop_ff;
   assign marker_ok   = rsp_last_ff && (rsp_index_ff == '0) && (rsp_value_ff == '0);

   `SSM_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ok)
   `SSM_ASSERT_IMP(a_mul_has_work, clock, reset, state_ff == S_MUL, has_l || has_r)
   `SSM_ASSERT_NXT(a_run_clears, clock, reset, last_load, lists_clear)
   `SSM_ASSERT_IMP(a_marker_form, clock, reset, rsp_valid_ff && rsp_empty_ff, marker_ok)

endmodule
